// ----- rtl/ssbag_pkg.sv -----
// ----------------------------------------------------------------------------
// ssbag_pkg
// Shared types and codes for the strided stream beat address generator.
// ----------------------------------------------------------------------------
package ssbag_pkg;

  localparam int ADDR_BITS  = 32;  // address arithmetic width, wraps at 2^ADDR_BITS
  localparam int DATA_BITS  = 32;  // configuration and counter width
  localparam int WIDTH_BITS = 12;  // req_width field
  localparam int BEAT_BITS  = 7;   // beat_bytes / port size field
  localparam int IDX_BITS   = 3;   // configuration register index
  localparam int CNT_BITS   = $clog2(DATA_BITS);

  localparam logic [BEAT_BITS-1:0] PORT_MAX = BEAT_BITS'(64);
  localparam logic [BEAT_BITS-1:0] PORT_RST = BEAT_BITS'(4);

  // configuration register indexes
  typedef enum logic [IDX_BITS-1:0] {
    REG_BASE_ADDRESS = 3'd0,
    REG_TOTAL_LEN    = 3'd1,
    REG_RUN_LEN      = 3'd2,
    REG_RUN_STRIDE   = 3'd3,
    REG_GROUP_LEN    = 3'd4,
    REG_GROUP_STRIDE = 3'd5,
    REG_PORT_SIZE    = 3'd6
  } reg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_ISSUED   = 2'd0,
    ST_FINISHED = 2'd1,
    ST_ZERO     = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_RUN,
    S_DIV_GRP,
    S_MUL_GRP,
    S_MUL_RUN,
    S_SUM,
    S_FIN
  } seq_state_t;

endpackage

// ----- rtl/strided_stream_beat_address_generator.sv -----
// ----------------------------------------------------------------------------
// strided_stream_beat_address_generator
// Turns beat requests into addresses of a two-level strided walk.
// ----------------------------------------------------------------------------
// Sequence: a linear walk (run_len 0) goes from input accept straight to the finish
//   step; a strided walk first runs two 32-step divisions, two multiplies and a sum.
// Flow: no new item is taken until the result is in the output register; the shared
//   radix-2 divider yields one quotient bit per cycle. A stalled result holds the
//   sequencer in its last step until the output register frees.
// Reset: rst_n synchronous active low; control and configuration registers to reset values, no result pending.
module strided_stream_beat_address_generator
  import ssbag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [11:0] req_width, [15:12] zero
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata,  // [31:0] beat_address, [38:32] beat_bytes,
                                            // [70:39] beat_number, [71] zero
  output logic [1:0]            out_tuser,  // [1:0] status
  output logic                  out_tlast,  // finished_after
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_BITS-1:0]   cfg_index,
  input  logic [DATA_BITS-1:0]  cfg_data
);

  // configuration
  logic [DATA_BITS-1:0] base_r,  base_nxt;
  logic [DATA_BITS-1:0] total_r, total_nxt;
  logic [DATA_BITS-1:0] rlen_r,  rlen_nxt;
  logic [DATA_BITS-1:0] rstr_r,  rstr_nxt;
  logic [DATA_BITS-1:0] glen_r,  glen_nxt;
  logic [DATA_BITS-1:0] gstr_r,  gstr_nxt;
  logic [BEAT_BITS-1:0] port_r,  port_nxt;

  // walk state
  logic [DATA_BITS-1:0] pos_r,   pos_nxt;
  logic [DATA_BITS-1:0] count_r, count_nxt;

  // sequencer and shared units
  seq_state_t           state_r, state_nxt;
  logic [CNT_BITS-1:0]  step_r,  step_nxt;
  logic [DATA_BITS-1:0] quo_r,   quo_nxt;   // dividend shifting out, quotient in
  logic [DATA_BITS-1:0] rem_r,   rem_nxt;
  logic [DATA_BITS-1:0] off_r,   off_nxt;   // offset within run
  logic [ADDR_BITS-1:0] acc_r,   acc_nxt;   // address accumulator
  logic [ADDR_BITS-1:0] prod_r,  prod_nxt;
  logic [WIDTH_BITS-1:0] width_r, width_nxt;

  // output register
  logic                 ovalid_r, ovalid_nxt;
  logic [1:0]           ostat_r,  ostat_nxt;
  logic [ADDR_BITS-1:0] oaddr_r,  oaddr_nxt;
  logic [BEAT_BITS-1:0] obytes_r, obytes_nxt;
  logic [DATA_BITS-1:0] onum_r,   onum_nxt;
  logic                 ofin_r,   ofin_nxt;

  // shared divider step
  logic [DATA_BITS-1:0] div_den;
  logic [DATA_BITS:0]   div_trial;
  logic                 div_ge;
  logic [DATA_BITS:0]   div_diff;

  // shared multiplier
  logic [DATA_BITS-1:0]   mul_a, mul_b;
  logic [2*DATA_BITS-1:0] mul_full;

  // finish-cycle beat sizing
  logic [BEAT_BITS-1:0] port_eff;
  logic [BEAT_BITS-1:0] beat;
  logic [DATA_BITS-1:0] left;
  logic [DATA_BITS-1:0] pos_adv;
  logic                 was_done;
  logic                 out_free;
  logic                 in_acc;
  logic                 out_acc;
  logic                 cfg_acc;

  // writes only while idle; a pending write goes ahead of a new item
  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = ovalid_r & out_tready;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign out_free  = !ovalid_r || out_tready;

  // group length 0 behaves as 1
  assign div_den   = (state_r == S_DIV_RUN) ? rlen_r :
                     ((glen_r == '0) ? DATA_BITS'(1) : glen_r);
  assign div_trial = {rem_r, quo_r[DATA_BITS-1]};
  assign div_ge    = div_trial >= {1'b0, div_den};
  assign div_diff  = div_trial - {1'b0, div_den};

  // low word only: the address wraps anyway
  assign mul_a    = (state_r == S_MUL_GRP) ? quo_r  : rem_r;
  assign mul_b    = (state_r == S_MUL_GRP) ? gstr_r : rstr_r;
  assign mul_full = mul_a * mul_b;

  always_comb begin
    // port size clamp: 0 acts as 1, above 64 acts as 64
    if (port_r == '0) begin
      port_eff = BEAT_BITS'(1);
    end else if (port_r > PORT_MAX) begin
      port_eff = PORT_MAX;
    end else begin
      port_eff = port_r;
    end
    left = rlen_r - off_r;
    if (width_r < WIDTH_BITS'(port_eff)) begin
      beat = width_r[BEAT_BITS-1:0];
    end else begin
      beat = port_eff;
    end
    if ((rlen_r != '0) && (DATA_BITS'(beat) > left)) begin
      beat = left[BEAT_BITS-1:0];
    end
    was_done = (pos_r >= total_r);
    pos_adv  = pos_r + DATA_BITS'(beat);
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    off_nxt    = off_r;
    acc_nxt    = acc_r;
    prod_nxt   = prod_r;
    width_nxt  = width_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    base_nxt   = base_r;
    total_nxt  = total_r;
    rlen_nxt   = rlen_r;
    rstr_nxt   = rstr_r;
    glen_nxt   = glen_r;
    gstr_nxt   = gstr_r;
    port_nxt   = port_r;
    ovalid_nxt = out_acc ? 1'b0 : ovalid_r;
    ostat_nxt  = ostat_r;
    oaddr_nxt  = oaddr_r;
    obytes_nxt = obytes_r;
    onum_nxt   = onum_r;
    ofin_nxt   = ofin_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          width_nxt = in_tdata[WIDTH_BITS-1:0];
          quo_nxt   = pos_r;
          rem_nxt   = '0;
          step_nxt  = '0;
          if (rlen_r == '0) begin
            acc_nxt   = ADDR_BITS'(base_r) + ADDR_BITS'(pos_r);
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DIV_RUN;
          end
        end
      end
      S_DIV_RUN, S_DIV_GRP: begin
        quo_nxt  = {quo_r[DATA_BITS-2:0], div_ge};
        rem_nxt  = div_ge ? div_diff[DATA_BITS-1:0] : div_trial[DATA_BITS-1:0];
        step_nxt = step_r + CNT_BITS'(1);
        if (step_r == CNT_BITS'(DATA_BITS - 1)) begin
          if (state_r == S_DIV_RUN) begin
            // quotient is the run index, next split it into group / run in group
            off_nxt   = rem_nxt;
            acc_nxt   = ADDR_BITS'(base_r) + ADDR_BITS'(rem_nxt);
            rem_nxt   = '0;
            state_nxt = S_DIV_GRP;
          end else begin
            state_nxt = S_MUL_GRP;
          end
        end
      end
      S_MUL_GRP: begin
        prod_nxt  = ADDR_BITS'(mul_full[DATA_BITS-1:0]);
        state_nxt = S_MUL_RUN;
      end
      S_MUL_RUN: begin
        acc_nxt   = acc_r + prod_r;
        prod_nxt  = ADDR_BITS'(mul_full[DATA_BITS-1:0]);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        acc_nxt   = acc_r + prod_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          oaddr_nxt  = acc_r;
          if (was_done) begin
            ostat_nxt  = ST_FINISHED;
            obytes_nxt = '0;
            onum_nxt   = count_r;
            ofin_nxt   = 1'b1;
          end else if (width_r == '0) begin
            ostat_nxt  = ST_ZERO;
            obytes_nxt = '0;
            onum_nxt   = count_r;
            ofin_nxt   = 1'b0;
          end else begin
            ostat_nxt  = ST_ISSUED;
            obytes_nxt = beat;
            onum_nxt   = count_r + DATA_BITS'(1);
            ofin_nxt   = (pos_adv >= total_r);
            pos_nxt    = pos_adv;
            count_nxt  = count_r + DATA_BITS'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // writes arrive only while idle; any listed register restarts the walk
    if (cfg_acc) begin
      case (cfg_index)
        REG_BASE_ADDRESS: base_nxt  = cfg_data;
        REG_TOTAL_LEN:    total_nxt = cfg_data;
        REG_RUN_LEN:      rlen_nxt  = cfg_data;
        REG_RUN_STRIDE:   rstr_nxt  = cfg_data;
        REG_GROUP_LEN:    glen_nxt  = cfg_data;
        REG_GROUP_STRIDE: gstr_nxt  = cfg_data;
        REG_PORT_SIZE:    port_nxt  = cfg_data[BEAT_BITS-1:0];
        default: ;
      endcase
      if (cfg_index <= REG_PORT_SIZE) begin
        pos_nxt   = '0;
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      base_r   <= '0;
      total_r  <= '0;
      rlen_r   <= '0;
      rstr_r   <= '0;
      glen_r   <= '0;
      gstr_r   <= '0;
      port_r   <= PORT_RST;
      pos_r    <= '0;
      count_r  <= '0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      base_r   <= base_nxt;
      total_r  <= total_nxt;
      rlen_r   <= rlen_nxt;
      rstr_r   <= rstr_nxt;
      glen_r   <= glen_nxt;
      gstr_r   <= gstr_nxt;
      port_r   <= port_nxt;
      pos_r    <= pos_nxt;
      count_r  <= count_nxt;
      step_r   <= step_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    off_r    <= off_nxt;
    acc_r    <= acc_nxt;
    prod_r   <= prod_nxt;
    width_r  <= width_nxt;
    ostat_r  <= ostat_nxt;
    oaddr_r  <= oaddr_nxt;
    obytes_r <= obytes_nxt;
    onum_r   <= onum_nxt;
    ofin_r   <= ofin_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = ofin_r;
  assign out_tdata  = {1'b0, onum_r, obytes_r, oaddr_r[31:0]};

endmodule

// ----- rtl/ssbag_checker.sv -----
// ----------------------------------------------------------------------------
// ssbag_checker
// Port-level checks for the strided stream beat address generator.
// ----------------------------------------------------------------------------
module ssbag_checker
  import ssbag_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // busy after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous one in progress");

  // no beat unless issued
  a_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FINISHED || out_tuser == ST_ZERO) |->
      out_tdata[38:32] == 7'd0)
    else $error("beat bytes on a result with no beat");

  // issued beat is 1..64 bytes
  a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_ISSUED |->
      out_tdata[38:32] != 7'd0 && out_tdata[38:32] <= 7'd64)
    else $error("issued beat size out of range");

  // a finished stream reports finished-after
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FINISHED |-> out_tlast)
    else $error("finished status without last flag");

endmodule

bind strided_stream_beat_address_generator ssbag_checker u_ssbag_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
